@@ rtl/lpf_pkg.sv @@
`timescale 1ns / 1ps

package lpf_pkg;

  // status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/lpf_div.sv @@
`timescale 1ns / 1ps

module lpf_div #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DATA_WIDTH-1:0]   dividend_i,
  input  logic [DATA_WIDTH-1:0]   divisor_i,
  output logic [DATA_WIDTH-1:0]   quotient_o,
  output logic [DATA_WIDTH-1:0]   remainder_o,
  output lpf_pkg::div_status_t    status_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);
  localparam logic [CntW-1:0] LastStep = CntW'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;

  // one restoring step: shift in the next dividend bit and try a subtract
  assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (diff[DATA_WIDTH]) begin
        rem_d = shifted[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
      end else begin
        rem_d = diff[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

@@ rtl/largest_prime_factor_core.sv @@
`timescale 1ns / 1ps
// Largest prime factor by trial division.
// Input channel: in_valid_i / in_ready_o carry number_i. in_ready_o is high
// only while the sequencer is idle; one number is factored at a time.
// Output channel: out_valid_o / out_ready_i carry largest_factor_o and
// no_factor_o. The result sits in an output register, so a new number may
// be taken while the previous result still waits for the receiver.
// Inputs 0 and 1 give factor 0 with no_factor_o set, without using the divider.
// Otherwise each trial step is one pass of the shared restoring divider
// (start, DATA_WIDTH shift/subtract steps, decision).
// Steps = number of divisors tried (up to about sqrt of the number, so up to
// 2^(DATA_WIDTH/2)) plus one per prime factor divided out.
// When the receiver stalls, a finished result waits in the sequencer until
// the output register frees; nothing is dropped.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle; any number in progress is abandoned.
module largest_prime_factor_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] number_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] largest_factor_o,
  output logic                  no_factor_o
);

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StWait,
    StDone
  } state_e;

  localparam logic [DATA_WIDTH-1:0] One = DATA_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0] Two = DATA_WIDTH'(2);

  state_e                state_q;
  logic [DATA_WIDTH-1:0] n_q;
  logic [DATA_WIDTH-1:0] d_q;
  logic [DATA_WIDTH-1:0] best_q;
  logic                  fresh_q;
  logic                  nf_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_factor_q;
  logic                  out_nf_q;

  logic                  div_start;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rem;
  lpf_pkg::div_status_t  div_st;
  logic                  slot_free;

  // shared divider computes n / d and n % d
  lpf_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .quotient_o  (quo),
    .remainder_o (rem),
    .status_o    (div_st)
  );

  assign div_start = (state_q == StStart);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      n_q          <= '0;
      d_q          <= '0;
      best_q       <= '0;
      fresh_q      <= 1'b0;
      nf_q         <= 1'b0;
      out_factor_q <= '0;
      out_nf_q     <= 1'b0;
    end else begin
      // output drains unless a new result is loaded below
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            n_q     <= number_i;
            d_q     <= Two;
            best_q  <= '0;
            fresh_q <= 1'b1;
            if (number_i < Two) begin
              nf_q    <= 1'b1;
              state_q <= StDone;
            end else begin
              nf_q    <= 1'b0;
              state_q <= StStart;
            end
          end
        end
        StStart: begin
          state_q <= StWait;
        end
        StWait: begin
          if (div_st.done) begin
            if (fresh_q && (d_q > quo)) begin
              // divisor squared exceeds the remaining number: it is prime or one
              if (n_q > One) begin
                best_q <= n_q;
              end
              state_q <= StDone;
            end else if (rem == '0) begin
              // divide out and retry the same divisor
              n_q     <= quo;
              best_q  <= d_q;
              fresh_q <= 1'b0;
              state_q <= StStart;
            end else begin
              d_q     <= d_q + One;
              fresh_q <= 1'b1;
              state_q <= StStart;
            end
          end
        end
        StDone: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_factor_q <= best_q;
            out_nf_q     <= nf_q;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign largest_factor_o = out_factor_q;
  assign no_factor_o      = out_nf_q;

endmodule

@@ verif/largest_prime_factor_core_test.sv @@
`timescale 1ns / 1ps

module largest_prime_factor_core_test;

  localparam int unsigned DW = 32;
  localparam longint unsigned MAX_VALUE = (64'd1 << DW) - 1;
  // random numbers are kept only when the divider needs few passes
  localparam int unsigned PASS_CAP = 600;
  localparam int unsigned RANDOM_NUMBERS = 80;
  localparam int unsigned IDLE_PCT = 22;
  localparam int unsigned CALM_FROM = 60;
  localparam int unsigned CALM_TO = 90;
  localparam int unsigned HOLD_AFTER = 5;
  localparam int unsigned HOLD_CYCLES = 15000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [DW-1:0] factor;
    logic          none;
  } factor_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] number = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] factor;
  logic          no_factor;

  logic [DW-1:0]  pending_numbers[$];
  factor_result_t factor_queue[$];
  factor_result_t oldest;
  int unsigned    numbers_taken = 0;
  int unsigned    results_seen = 0;
  int unsigned    mismatches = 0;
  int unsigned    hold_left = 0;
  logic           held = 1'b0;
  int unsigned    quiet_cycles = 0;

  largest_prime_factor_core #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .number_i        (number),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .largest_factor_o(factor),
    .no_factor_o     (no_factor)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // largest prime factor by trial division, zero and one have none
  function automatic factor_result_t predict_factor(input logic [DW-1:0] value);
    factor_result_t  res;
    longint unsigned rest;
    longint unsigned divisor;
    longint unsigned best;
    rest = value;
    best = 0;
    divisor = 2;
    if (rest < 2) begin
      res.factor = '0;
      res.none = 1'b1;
    end else begin
      while (divisor <= rest / divisor) begin
        while (rest % divisor == 0) begin
          rest = rest / divisor;
          best = divisor;
        end
        divisor++;
      end
      if (rest > 1) best = rest;
      res.factor = best[DW-1:0];
      res.none = 1'b0;
    end
    return res;
  endfunction

  // divider passes the block spends on a number, stops counting past cap
  function automatic int unsigned divider_passes(input longint unsigned value,
                                                 input int unsigned cap);
    longint unsigned rest;
    longint unsigned divisor;
    int unsigned     passes;
    rest = value;
    divisor = 2;
    passes = 0;
    while (rest >= 2 && divisor <= rest / divisor && passes <= cap) begin
      passes++;
      while (rest % divisor == 0 && passes <= cap) begin
        rest = rest / divisor;
        passes++;
      end
      divisor++;
    end
    return passes;
  endfunction

  // mix of smooth products, small values, shifted values and cheap wide values
  function automatic logic [DW-1:0] pick_number();
    int unsigned     kind;
    longint unsigned val;
    longint unsigned mult;
    logic            ok;
    ok = 1'b0;
    val = 0;
    while (!ok) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        val = 1;
        repeat ($urandom_range(1, 12)) begin
          mult = $urandom_range(2, 97);
          if (val * mult <= MAX_VALUE) val = val * mult;
        end
      end else if (kind < 60) begin
        val = $urandom_range(0, 65535);
      end else if (kind < 85) begin
        val = (longint'($urandom_range(1, 4095)) << $urandom_range(0, DW - 1)) & MAX_VALUE;
      end else begin
        val = $urandom & MAX_VALUE;
      end
      ok = (divider_passes(val, PASS_CAP) <= PASS_CAP);
    end
    return val[DW-1:0];
  endfunction

  // sender: offers pending numbers, predicts each accepted transaction
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      number <= '0;
    end else begin
      if (in_valid && in_ready) begin
        factor_queue.push_back(predict_factor(number));
        numbers_taken <= numbers_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_numbers.size() != 0 &&
            ((numbers_taken >= CALM_FROM && numbers_taken < CALM_TO) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          number <= pending_numbers.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results against the oldest prediction, stalls at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      held <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (factor_queue.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: factor %0d no_factor %0b", factor, no_factor);
          mismatches <= mismatches + 1;
        end else begin
          oldest = factor_queue.pop_front();
          if (oldest.factor !== factor || oldest.none !== no_factor) begin
            if (mismatches < MAX_REPORTS)
              $display("mismatch on result %0d: factor exp %0d got %0d, no_factor exp %0b got %0b",
                       results_seen, oldest.factor, factor, oldest.none, no_factor);
            mismatches <= mismatches + 1;
          end
        end
      end
      // one long hold-off early on so the block fills and stalls its input
      if (!held && results_seen == HOLD_AFTER) begin
        held <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= CALM_FROM && results_seen < CALM_TO) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    // zero and one, small values, primes, squares, full and sparse patterns
    pending_numbers.push_back(32'd0);
    pending_numbers.push_back(32'd1);
    pending_numbers.push_back(32'd2);
    pending_numbers.push_back(32'd3);
    pending_numbers.push_back(32'd4);
    pending_numbers.push_back(32'hFFFF_FFFF);
    pending_numbers.push_back(32'h8000_0000);
    pending_numbers.push_back(32'd6);
    pending_numbers.push_back(32'd8);
    pending_numbers.push_back(32'd12);
    pending_numbers.push_back(32'd49);
    pending_numbers.push_back(32'd97);
    pending_numbers.push_back(32'd65521);
    pending_numbers.push_back(32'd1000003);
    pending_numbers.push_back(32'd63001);
    pending_numbers.push_back(32'hAAAA_AAAA);
    pending_numbers.push_back(32'h5555_5555);
    pending_numbers.push_back(32'hFFFF_0000);
    pending_numbers.push_back(32'd1024);
    pending_numbers.push_back(32'd0);
    pending_numbers.push_back(32'd1);
    repeat (RANDOM_NUMBERS) pending_numbers.push_back(pick_number());

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (!(pending_numbers.size() == 0 && !in_valid)) @(posedge clk);
    while (factor_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && factor_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lpf_pkg.sv
rtl/lpf_div.sv
rtl/largest_prime_factor_core.sv
verif/largest_prime_factor_core_test.sv
